@@ sv/timed_half_step_stepper_sequencer_defines.svh @@
// assertion macros for the half-step stepper sequencer
`ifndef TIMED_HALF_STEP_STEPPER_SEQUENCER_DEFINES_SVH
`define TIMED_HALF_STEP_STEPPER_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define THSS_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("thss assertion failed");
`define THSS_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("thss assertion failed");
`else
`define THSS_ASSERT(name, clk, rst_n, prop)
`define THSS_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

@@ sv/thss_pkg.sv @@
// types, codes and coil pattern table for the half-step stepper sequencer
package thss_pkg;

    localparam logic [1:0] REQ_MOVE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_STOP = 2'd2;

    localparam logic [1:0] DIR_OPEN  = 2'd0;
    localparam logic [1:0] DIR_CLOSE = 2'd1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_BUSY    = 2'd2;

    localparam logic [2:0] PHASE_FWD  = 3'd1;
    localparam logic [2:0] PHASE_BACK = 3'd7;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  move_dir;
        logic [31:0] step_count;
        logic [31:0] step_interval_ms;
        logic [31:0] now_ms;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] coil_bits;
        logic       busy_res;
    } t_res;

    function automatic logic [3:0] coil_pattern(input logic [2:0] phase);
        logic [3:0] pat;
        case (phase)
            3'd0:    pat = 4'd1;
            3'd1:    pat = 4'd3;
            3'd2:    pat = 4'd2;
            3'd3:    pat = 4'd6;
            3'd4:    pat = 4'd4;
            3'd5:    pat = 4'd12;
            3'd6:    pat = 4'd8;
            default: pat = 4'd9;
        endcase
        return pat;
    endfunction

endpackage

@@ sv/thss_if.sv @@
// request and result channel interfaces for the half-step stepper sequencer
interface thss_req_if;
    logic            valid;
    logic            ready;
    thss_pkg::t_req  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface thss_res_if;
    logic            valid;
    logic            ready;
    thss_pkg::t_res  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/timed_half_step_stepper_sequencer.sv @@
// Half-step sequencer for a four-coil unipolar stepper. Each request word (move, tick or
// stop) yields exactly one result word: it is held in the input register, then goes through
// the decode and state update into the result register. A new word is taken every cycle as
// long as the result side keeps taking words; the result register frees the input side
// whenever its word is taken in the same cycle. Throughput is one word per cycle while the
// result side takes words; the step update (32-bit deadline compare, deadline add and step
// count decrement) is combinational. Coils go off after the last step and on stop.
`include "timed_half_step_stepper_sequencer_defines.svh"

module timed_half_step_stepper_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    thss_req_if.sink          i_req,
    thss_res_if.source        o_res
);

    logic            r_in_valid;
    thss_pkg::t_req  r_in;
    logic            r_out_valid;
    thss_pkg::t_res  r_out;

    logic [31:0] r_steps_left;
    logic [31:0] r_step_period;
    logic [31:0] r_next_step_time;
    logic        r_move_reverse;
    logic [2:0]  r_phase;
    logic [3:0]  r_coil_level;

    logic [31:0] n_steps_left;
    logic [31:0] n_step_period;
    logic [31:0] n_next_step_time;
    logic        n_move_reverse;
    logic [2:0]  n_phase;
    logic [3:0]  n_coil_level;
    logic [1:0]  n_status;

    logic        advance;
    logic        fire;
    logic [31:0] diff;
    logic        bad_move;

    assign advance     = !r_out_valid || o_res.ready;
    assign fire        = r_in_valid && advance;
    assign i_req.ready = !r_in_valid || advance;

    assign diff     = r_in.now_ms - r_next_step_time;
    assign bad_move = (r_in.move_dir != thss_pkg::DIR_OPEN &&
                       r_in.move_dir != thss_pkg::DIR_CLOSE) ||
                      r_in.step_count == 32'd0 || r_in.step_interval_ms == 32'd0;

    always_comb begin
        n_steps_left     = r_steps_left;
        n_step_period    = r_step_period;
        n_next_step_time = r_next_step_time;
        n_move_reverse   = r_move_reverse;
        n_phase          = r_phase;
        n_coil_level     = r_coil_level;
        n_status         = thss_pkg::STATUS_OK;
        unique case (r_in.req_type)
            thss_pkg::REQ_MOVE: begin
                if (bad_move) begin
                    n_status = thss_pkg::STATUS_INVALID;
                end else if (r_steps_left != 32'd0) begin
                    n_status = thss_pkg::STATUS_BUSY;
                end else begin
                    n_move_reverse   = r_in.move_dir[0];
                    n_steps_left     = r_in.step_count;
                    n_step_period    = r_in.step_interval_ms;
                    n_next_step_time = r_in.now_ms;
                end
            end
            thss_pkg::REQ_TICK: begin
                if (r_steps_left != 32'd0 && !diff[31]) begin
                    n_phase = r_phase + (r_move_reverse ? thss_pkg::PHASE_BACK
                                                        : thss_pkg::PHASE_FWD);
                    n_coil_level     = (r_steps_left == 32'd1) ? 4'd0
                                                               : thss_pkg::coil_pattern(n_phase);
                    n_next_step_time = r_next_step_time + r_step_period;
                    n_steps_left     = r_steps_left - 32'd1;
                end
            end
            thss_pkg::REQ_STOP: begin
                n_steps_left     = 32'd0;
                n_step_period    = 32'd0;
                n_next_step_time = 32'd0;
                n_move_reverse   = 1'b0;
                n_phase          = 3'd0;
                n_coil_level     = 4'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_steps_left     <= 32'd0;
            r_step_period    <= 32'd0;
            r_next_step_time <= 32'd0;
            r_move_reverse   <= 1'b0;
            r_phase          <= 3'd0;
            r_coil_level     <= 4'd0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_steps_left     <= n_steps_left;
                r_step_period    <= n_step_period;
                r_next_step_time <= n_next_step_time;
                r_move_reverse   <= n_move_reverse;
                r_phase          <= n_phase;
                r_coil_level     <= n_coil_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.payload;
        end
        if (fire) begin
            r_out.status    <= n_status;
            r_out.coil_bits <= n_coil_level;
            r_out.busy_res  <= (n_steps_left != 32'd0);
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    property p_phase_step;
        !$stable(r_phase) |-> (r_phase == $past(r_phase) + 3'd1 ||
                               r_phase == $past(r_phase) - 3'd1 || r_phase == 3'd0);
    endproperty

    property p_busy_consistent;
        (o_res.valid && o_res.payload.status == thss_pkg::STATUS_BUSY) |->
            o_res.payload.busy_res;
    endproperty

    // coils are only energized while a move is running
    `THSS_ASSERT(a_coils_need_move, i_clk, i_rst_n, |r_coil_level |-> |r_steps_left)
    // an item leaving the input register always lands in the result register
    `THSS_ASSERT(a_fire_fills_out, i_clk, i_rst_n, fire |=> r_out_valid)
    // phase moves by one half step or returns home on stop
    `THSS_ASSERT(a_phase_step, i_clk, i_rst_n, p_phase_step)
    // a busy rejection reports a running move
    `THSS_ASSERT(a_busy_consistent, i_clk, i_rst_n, p_busy_consistent)
    // nothing is pending right after reset
    `THSS_ASSERT_ALWAYS(a_reset_empty, i_clk, !$past(i_rst_n) |-> (!r_in_valid && !r_out_valid))

endmodule

@@ tb/thss_coil_check.sv @@
`timescale 1ns / 100ps
// watches both channels, predicts every result word and compares it field by field
module thss_coil_check
    import thss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    thss_req_if  i_req,
    thss_res_if  i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_step_total,
    output int   o_reject_total
);

    localparam logic [3:0] HALF_STEP_COILS [8] = '{
        4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9
    };

    logic [31:0] run_steps_left;
    logic [31:0] run_period;
    logic [31:0] run_deadline;
    logic        run_reverse;
    logic [2:0]  run_phase;
    logic [3:0]  run_coils;
    t_res        expected_words [$];

    function automatic void clear_run();
        run_steps_left = '0;
        run_period     = '0;
        run_deadline   = '0;
        run_reverse    = 1'b0;
        run_phase      = '0;
        run_coils      = '0;
    endfunction

    function automatic t_res predict_coil_word(input t_req w);
        t_res        r;
        logic [31:0] lag;
        r.status = STATUS_OK;
        case (w.req_type)
            REQ_MOVE: begin
                if ((w.move_dir != DIR_OPEN && w.move_dir != DIR_CLOSE) ||
                    w.step_count == '0 || w.step_interval_ms == '0) begin
                    r.status = STATUS_INVALID;
                end else if (run_steps_left != '0) begin
                    r.status = STATUS_BUSY;
                end else begin
                    run_reverse    = (w.move_dir == DIR_CLOSE);
                    run_steps_left = w.step_count;
                    run_period     = w.step_interval_ms;
                    run_deadline   = w.now_ms;
                end
            end
            REQ_TICK: begin
                lag = w.now_ms - run_deadline;
                if (run_steps_left != '0 && !lag[31]) begin
                    run_phase      = run_phase + (run_reverse ? PHASE_BACK : PHASE_FWD);
                    run_coils      = HALF_STEP_COILS[run_phase];
                    run_deadline   = run_deadline + run_period;
                    run_steps_left = run_steps_left - 1;
                    if (run_steps_left == '0)
                        run_coils = '0;
                    o_step_total++;
                end
            end
            REQ_STOP: begin
                clear_run();
            end
            default: ;
        endcase
        if (r.status != STATUS_OK)
            o_reject_total++;
        r.coil_bits = run_coils;
        r.busy_res  = (run_steps_left != '0);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            clear_run();
            expected_words.delete();
            o_fail_count   = 0;
            o_step_total   = 0;
            o_reject_total = 0;
        end else begin
            if (i_req.valid && i_req.ready)
                expected_words.push_back(predict_coil_word(i_req.payload));
            if (i_res.valid && i_res.ready) begin
                got = i_res.payload;
                if (expected_words.size() == 0) begin
                    $error("unexpected result word: status %0d coil_bits %0h busy_res %0d",
                           got.status, got.coil_bits, got.busy_res);
                    o_fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d actual %0d", want.status, got.status);
                        o_fail_count++;
                    end
                    if (got.coil_bits !== want.coil_bits) begin
                        $error("coil_bits: expected %0h actual %0h",
                               want.coil_bits, got.coil_bits);
                        o_fail_count++;
                    end
                    if (got.busy_res !== want.busy_res) begin
                        $error("busy_res: expected %0d actual %0d",
                               want.busy_res, got.busy_res);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_words.size();
    end

endmodule

@@ tb/tb_timed_half_step_stepper_sequencer.sv @@
`timescale 1ns / 100ps
// top: clock, reset, request and result stimulus, and the verdict for the stepper sequencer
module tb_timed_half_step_stepper_sequencer;
    import thss_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam logic [1:0] DIR_BAD_LO  = 2'd2;
    localparam logic [1:0] DIR_BAD_HI  = 2'd3;
    localparam int         ITEM_TARGET = 1175;
    localparam int         HOLD_CYCLES = 80;
    localparam int         CYCLE_LIMIT = 600000;

    logic        clk;
    logic        rst_n = 1'b0;
    int          fail_count;
    int          pending;
    int          step_total;
    int          reject_total;
    int          tx_max_gap;
    int          rx_max_gap;
    bit          long_hold;
    int          sent;
    int          cycles;
    logic [31:0] clock_ms;

    thss_req_if req_ch ();
    thss_res_if res_ch ();

    timed_half_step_stepper_sequencer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    thss_coil_check coil_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req          (req_ch),
        .i_res          (res_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_step_total   (step_total),
        .o_reject_total (reject_total)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[timed_half_step_stepper_sequencer] ERROR");
            $finish;
        end
    end

    function automatic t_req make_word(input logic [1:0] kind, input logic [1:0] dir,
                                       input logic [31:0] count, input logic [31:0] interval,
                                       input logic [31:0] now);
        t_req w;
        w.req_type         = kind;
        w.move_dir         = dir;
        w.step_count       = count;
        w.step_interval_ms = interval;
        w.now_ms           = now;
        return w;
    endfunction

    task automatic send_word(input t_req w);
        int gap;
        gap = $urandom_range(tx_max_gap);
        @(negedge clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= w;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sent++;
    endtask

    task automatic send_move(input logic [1:0] dir, input logic [31:0] count,
                             input logic [31:0] interval, input logic [31:0] now);
        send_word(make_word(REQ_MOVE, dir, count, interval, now));
    endtask

    task automatic send_tick(input logic [31:0] now);
        send_word(make_word(REQ_TICK, 2'($urandom), $urandom, $urandom, now));
    endtask

    task automatic send_stop();
        send_word(make_word(REQ_STOP, 2'($urandom), $urandom, $urandom, $urandom));
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // one move and the ticks that walk it, with the odd rejected move, stop or time jump
    task automatic run_move_sequence();
        logic [1:0]  dir;
        logic [31:0] count;
        logic [31:0] interval;
        int          ticks;
        int          pick;
        dir      = $urandom_range(1) ? DIR_CLOSE : DIR_OPEN;
        count    = ($urandom_range(9) == 0) ? $urandom : $urandom_range(10, 1);
        interval = ($urandom_range(7) == 0) ? $urandom : $urandom_range(40, 1);
        clock_ms = ($urandom_range(3) == 0) ? $urandom : clock_ms + $urandom_range(100);
        send_move(dir, count, interval, clock_ms);
        ticks = (count > 12 ? 12 : count) * 2 + $urandom_range(3);
        for (int i = 0; i < ticks; i++) begin
            pick = $urandom_range(19);
            if (pick == 0) begin
                send_move(2'($urandom), ($urandom_range(1) ? $urandom : $urandom_range(3)),
                          ($urandom_range(1) ? $urandom : $urandom_range(3)), clock_ms);
            end else if (pick == 1 && $urandom_range(3) == 0) begin
                send_stop();
                break;
            end else begin
                if (pick == 2)
                    clock_ms = clock_ms - $urandom_range(50);
                else if (pick == 3)
                    clock_ms = clock_ms + $urandom;
                else if (interval > 1000)
                    clock_ms = clock_ms + $urandom_range(60);
                else
                    clock_ms = clock_ms + $urandom_range(interval + interval / 2);
                send_tick(clock_ms);
            end
        end
        if ($urandom_range(1))
            send_stop();
    endtask

    task automatic run_noise();
        int n;
        n = $urandom_range(6, 1);
        repeat (n) begin
            send_word(make_word(2'($urandom), 2'($urandom), $urandom, $urandom,
                                ($urandom_range(1) ? $urandom : clock_ms)));
        end
    endtask

    function automatic int pick_gap_limit();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 4;
            default: return 13;
        endcase
    endfunction

    // result side: random stalls, plus one long hold-off when asked
    initial begin
        int gap;
        @(posedge rst_n);
        forever begin
            gap = $urandom_range(rx_max_gap);
            if (long_hold) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
            end else if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(res_ch.valid && res_ch.ready)) @(posedge clk);
            @(negedge clk);
        end
    end

    initial begin
        int seq_no;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        res_ch.ready   = 1'b0;
        tx_max_gap     = 0;
        rx_max_gap     = 0;
        long_hold      = 1'b0;
        sent           = 0;
        cycles         = 0;
        clock_ms       = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed
        send_tick(32'd0);
        send_stop();
        send_word(make_word(REQ_UNUSED, DIR_OPEN, 32'd4, 32'd4, 32'd0));
        send_move(DIR_BAD_LO, 32'd5, 32'd5, 32'd0);
        send_move(DIR_BAD_HI, 32'd5, 32'd5, 32'd0);
        send_move(DIR_OPEN, 32'd0, 32'd5, 32'd0);
        send_move(DIR_OPEN, 32'd5, 32'd0, 32'd0);
        send_move(DIR_OPEN, 32'd3, 32'd10, 32'd100);
        send_move(DIR_CLOSE, 32'd2, 32'd5, 32'd100);
        send_move(DIR_BAD_HI, 32'd0, 32'd0, 32'd100);
        send_tick(32'd99);
        send_tick(32'd100);
        send_tick(32'd105);
        send_tick(32'd110);
        send_tick(32'd120);
        send_tick(32'd130);
        send_move(DIR_CLOSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_tick(32'hFFFF_FFF0);
        send_tick(32'h7FFF_FFEF);
        send_tick(32'h7FFF_FFEE);
        send_stop();
        send_tick(32'hFFFF_FFFF);
        send_move(DIR_OPEN, 32'd1, 32'd1, 32'h8000_0000);
        send_tick(32'h8000_0000);
        drain_results();

        // random
        seq_no = 0;
        while (sent < ITEM_TARGET) begin
            tx_max_gap = pick_gap_limit();
            rx_max_gap = pick_gap_limit();
            if (seq_no == 3) begin
                tx_max_gap = 0;
                long_hold  = 1'b1;
            end
            if ($urandom_range(9) < 7)
                run_move_sequence();
            else
                run_noise();
            if (seq_no % 20 == 19)
                drain_results();
            seq_no++;
        end

        drain_results();
        repeat (8) @(negedge clk);
        $display("covered %0d request words in %0d runs: %0d coil steps, %0d rejected moves",
                 sent, seq_no, step_total, reject_total);
        if (fail_count == 0)
            $display("[timed_half_step_stepper_sequencer] OK");
        else
            $display("[timed_half_step_stepper_sequencer] ERROR");
        $finish;
    end

endmodule
